// File: sv/semaphore_table_fifo_waiters_macros.svh
// Assertion macros for the semaphore table.
// Used by semaphore_table_fifo_waiters.sv; expects clk and rst_n in scope.
`ifndef SEMAPHORE_TABLE_FIFO_WAITERS_MACROS_SVH
`define SEMAPHORE_TABLE_FIFO_WAITERS_MACROS_SVH

// same-cycle implication
`define SEMT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SEMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/semt_pkg.sv
// Shared types and constants for the semaphore table.
// No dependencies; used by semt_decide and semaphore_table_fifo_waiters.
package semt_pkg;

  localparam int NUM_SEMAPHORES_DEF = 8;
  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int PID_BITS_DEF       = 8;

  localparam int OP_W    = 2;
  localparam int SID_W   = 3;
  localparam int COUNT_W = 16;
  localparam int PID_W   = 8;

  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7fff;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 2'd0,
    OP_WAIT   = 2'd1,
    OP_SIGNAL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_ENABLED = 2'd1,
    ST_ALREADY     = 2'd2,
    ST_QUEUE_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    status_t status;
    logic    caller_blocked;
    logic    enqueue;
    logic    dequeue;
    logic    reschedule;
    logic    wr_desc;
  } decide_t;

endpackage

// File: sv/semt_decide.sv
// Request decision for one semaphore descriptor: new count, queue pointers, status.
// Depends on semt_pkg.
module semt_decide #(
  parameter int NUM_SEMAPHORES = semt_pkg::NUM_SEMAPHORES_DEF,
  parameter int QUEUE_DEPTH    = semt_pkg::QUEUE_DEPTH_DEF,
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int FW = $clog2(QUEUE_DEPTH + 1)
) (
  input  semt_pkg::op_t                       op,
  input  logic [semt_pkg::SID_W-1:0]          sem_id,
  input  logic signed [semt_pkg::COUNT_W-1:0] init_value,
  input  logic                                init_running,
  input  logic                                en,
  input  logic signed [semt_pkg::COUNT_W-1:0] count,
  input  logic [QW-1:0]                       head,
  input  logic [FW-1:0]                       fill,
  output semt_pkg::decide_t                   ctl,
  output logic                                new_en,
  output logic signed [semt_pkg::COUNT_W-1:0] new_count,
  output logic [QW-1:0]                       new_head,
  output logic [FW-1:0]                       new_fill,
  output logic [QW-1:0]                       tail
);

  localparam logic [FW:0] DEPTH_V = (FW+1)'(QUEUE_DEPTH);

  logic [FW:0]                       tail_sum;
  logic [FW:0]                       head_inc;
  logic signed [semt_pkg::COUNT_W-1:0] cnt_dec;
  logic signed [semt_pkg::COUNT_W-1:0] cnt_inc;

  always_comb begin
    tail_sum = (FW+1)'(head) + (FW+1)'(fill);
    if (tail_sum >= DEPTH_V) begin
      tail_sum = tail_sum - DEPTH_V;
    end
    tail = tail_sum[QW-1:0];
    head_inc = (FW+1)'(head) + (FW+1)'(1);
    if (head_inc >= DEPTH_V) begin
      head_inc = head_inc - DEPTH_V;
    end
    cnt_dec = (count == semt_pkg::COUNT_MIN) ? count : count - 16'sd1;
    cnt_inc = (count == semt_pkg::COUNT_MAX) ? count : count + 16'sd1;
  end

  always_comb begin
    ctl        = '0;
    ctl.status = semt_pkg::ST_OK;
    new_en     = en;
    new_count  = count;
    new_head   = head;
    new_fill   = fill;
    case (op)
      semt_pkg::OP_CREATE, semt_pkg::OP_WAIT, semt_pkg::OP_SIGNAL: begin
        if (int'(sem_id) >= NUM_SEMAPHORES) begin
          ctl.status = semt_pkg::ST_NOT_ENABLED;
        end else if (op == semt_pkg::OP_CREATE) begin
          if (en) begin
            ctl.status = semt_pkg::ST_ALREADY;
          end else begin
            new_en      = 1'b1;
            new_count   = init_value;
            ctl.wr_desc = 1'b1;
          end
        end else if (!en) begin
          ctl.status = semt_pkg::ST_NOT_ENABLED;
        end else if (op == semt_pkg::OP_WAIT) begin
          if (cnt_dec[semt_pkg::COUNT_W-1] && !init_running) begin
            if (fill >= DEPTH_V[FW-1:0]) begin
              ctl.status = semt_pkg::ST_QUEUE_FULL;
            end else begin
              new_fill           = fill + FW'(1);
              new_count          = cnt_dec;
              ctl.enqueue        = 1'b1;
              ctl.caller_blocked = 1'b1;
              ctl.wr_desc        = 1'b1;
            end
          end else begin
            new_count   = cnt_dec;
            ctl.wr_desc = 1'b1;
          end
        end else begin
          new_count   = cnt_inc;
          ctl.wr_desc = 1'b1;
          if ((cnt_inc[semt_pkg::COUNT_W-1] || cnt_inc == '0) && fill != '0) begin
            new_head       = head_inc[QW-1:0];
            new_fill       = fill - FW'(1);
            ctl.dequeue    = 1'b1;
            ctl.reschedule = init_running;
          end
        end
      end
      default: begin
        ctl.status = semt_pkg::ST_OK;
      end
    endcase
  end

endmodule

// File: sv/semaphore_table_fifo_waiters.sv
// Table of counting semaphores with per-semaphore FIFO wait queues.
// Depends on semt_pkg, semt_decide and semaphore_table_fifo_waiters_macros.svh.
// Timing: a request is taken when start is high and busy is low. Create, wait and a
// signal that releases nobody pass a descriptor memory read, then decide and write
// back; a signal that releases a waiter adds a read of the waiter memory. The result
// is registered and shown for exactly one cycle with out_strobe, in the cycle in which
// busy falls; it cannot be held off, so capture it then. A new request is not taken
// until the last one is done. Reset clears the table at once.
`include "semaphore_table_fifo_waiters_macros.svh"

module semaphore_table_fifo_waiters #(
  parameter int NUM_SEMAPHORES = semt_pkg::NUM_SEMAPHORES_DEF,
  parameter int QUEUE_DEPTH    = semt_pkg::QUEUE_DEPTH_DEF,
  parameter int PID_BITS       = semt_pkg::PID_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [semt_pkg::OP_W-1:0]           in_operation,
  input  logic [semt_pkg::SID_W-1:0]          in_sem_id,
  input  logic signed [semt_pkg::COUNT_W-1:0] in_init_value,
  input  logic [semt_pkg::PID_W-1:0]          in_caller_pid,
  input  logic                                in_init_running,
  output logic                                out_strobe,
  output logic [1:0]                          out_status,
  output logic                                out_caller_blocked,
  output logic                                out_woken_valid,
  output logic [semt_pkg::PID_W-1:0]          out_woken_pid,
  output logic                                out_reschedule
);

  localparam int SW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int WDEPTH = NUM_SEMAPHORES * QUEUE_DEPTH;
  localparam int AW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int DW = 1 + semt_pkg::COUNT_W + QW + FW;
  localparam int PXW = PID_BITS + semt_pkg::PID_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_WAKE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [semt_pkg::OP_W-1:0]           op_r;
  logic [semt_pkg::SID_W-1:0]          sid_r;
  logic signed [semt_pkg::COUNT_W-1:0] ival_r;
  logic [semt_pkg::PID_W-1:0]          pid_r;
  logic                                init_r;
  logic [SW-1:0]                       idx_r;
  logic [SW-1:0]                       idx_in;

  logic [DW-1:0]             desc_mem [NUM_SEMAPHORES];
  logic [NUM_SEMAPHORES-1:0] vld_r;
  logic [DW-1:0]             desc_rd_r;
  logic                      dvld_r;
  logic [DW-1:0]             desc_cur;

  logic [PID_BITS-1:0] wait_mem [WDEPTH];
  logic [PID_BITS-1:0] wrd_r;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [PXW-1:0]      pid_ext;
  logic [PXW-1:0]      wk_ext;

  logic                                cur_en;
  logic signed [semt_pkg::COUNT_W-1:0] cur_count;
  logic [QW-1:0]                       cur_head;
  logic [FW-1:0]                       cur_fill;

  semt_pkg::decide_t                   ctl;
  logic                                new_en;
  logic signed [semt_pkg::COUNT_W-1:0] new_count;
  logic [QW-1:0]                       new_head;
  logic [FW-1:0]                       new_fill;
  logic [QW-1:0]                       tail;

  logic resched_r;
  logic accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign idx_in = (int'(in_sem_id) < NUM_SEMAPHORES) ? SW'(in_sem_id) : '0;

  assign desc_cur = dvld_r ? desc_rd_r : '0;
  assign {cur_en, cur_count, cur_head, cur_fill} = desc_cur;

  assign waddr   = AW'(int'(idx_r) * QUEUE_DEPTH + int'(tail));
  assign raddr   = AW'(int'(idx_r) * QUEUE_DEPTH + int'(cur_head));
  assign pid_ext = {{PID_BITS{1'b0}}, pid_r};
  assign wk_ext  = {{semt_pkg::PID_W{1'b0}}, wrd_r};

  semt_decide #(
    .NUM_SEMAPHORES (NUM_SEMAPHORES),
    .QUEUE_DEPTH    (QUEUE_DEPTH)
  ) u_decide (
    .op           (semt_pkg::op_t'(op_r)),
    .sem_id       (sid_r),
    .init_value   (ival_r),
    .init_running (init_r),
    .en           (cur_en),
    .count        (cur_count),
    .head         (cur_head),
    .fill         (cur_fill),
    .ctl          (ctl),
    .new_en       (new_en),
    .new_count    (new_count),
    .new_head     (new_head),
    .new_fill     (new_fill),
    .tail         (tail)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = ctl.dequeue ? S_WAKE : S_IDLE;
      end
      S_WAKE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      vld_r      <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_strobe <= (state_r == S_WAKE) || (state_r == S_EXEC && !ctl.dequeue);
      if (state_r == S_EXEC && ctl.wr_desc) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  // capture request, read descriptor
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_operation;
      sid_r     <= in_sem_id;
      ival_r    <= in_init_value;
      pid_r     <= in_caller_pid;
      init_r    <= in_init_running;
      idx_r     <= idx_in;
      desc_rd_r <= desc_mem[idx_in];
      dvld_r    <= vld_r[idx_in];
    end
  end

  // write back descriptor
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && ctl.wr_desc) begin
      desc_mem[idx_r] <= {new_en, new_count, new_head, new_fill};
    end
  end

  // waiter store
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && ctl.enqueue) begin
      wait_mem[waddr] <= pid_ext[PID_BITS-1:0];
    end
    if (state_r == S_EXEC && ctl.dequeue) begin
      wrd_r <= wait_mem[raddr];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      out_status         <= ctl.status;
      out_caller_blocked <= ctl.caller_blocked;
      out_woken_valid    <= 1'b0;
      out_woken_pid      <= '0;
      out_reschedule     <= 1'b0;
      resched_r          <= ctl.reschedule;
    end else if (state_r == S_WAKE) begin
      out_woken_valid <= 1'b1;
      out_woken_pid   <= wk_ext[semt_pkg::PID_W-1:0];
      out_reschedule  <= resched_r;
    end
  end

  `SEMT_ASSERT_NEXT(a_accept_exec, accept, state_r == S_EXEC, "accepted request did not start")
  `SEMT_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe longer than one cycle")
  `SEMT_ASSERT_SAME(a_wake_ok, out_strobe && out_woken_valid,
    out_status == semt_pkg::ST_OK && !out_caller_blocked, "wake with bad status")
  `SEMT_ASSERT_SAME(a_wake_after_exec, state_r == S_WAKE, $past(state_r) == S_EXEC,
    "waiter read without decision")
  `SEMT_ASSERT_SAME(a_enq_room, state_r == S_EXEC && ctl.enqueue,
    int'(cur_fill) < QUEUE_DEPTH, "enqueue into full queue")

endmodule
